/* src/assert_macros.svh */
// Assertion macros shared by the luma motion detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is checked in every cycle.
`define LMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* src/lmd_pkg.sv */
// Types and constants shared by the luma motion detector modules.
`default_nettype none

package lmd_pkg;

    // Default sizes of the tile grid and of the frame.
    localparam int MAX_TILE_COLS_DEF = 128;
    localparam int MAX_TILE_ROWS_DEF = 128;
    localparam int MAX_DIM_DEF       = 4096;

    // Widths fixed by the register and stream formats.
    localparam int DIM_CFG_W  = 13;
    localparam int GRID_CFG_W = 8;
    localparam int LUMA_W     = 8;
    localparam int OUT_IDX_W  = 7;
    localparam int ACC_W      = 32;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = 6;

    // Register values after reset.
    localparam logic [DIM_CFG_W-1:0]  FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [DIM_CFG_W-1:0]  FRAME_HEIGHT_RST = 13'd1080;
    localparam logic [GRID_CFG_W-1:0] BLOCK_COLS_RST   = 8'd12;
    localparam logic [GRID_CFG_W-1:0] BLOCK_ROWS_RST   = 8'd8;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BLOCK_COLS   = 2'd2,
        REG_BLOCK_ROWS   = 2'd3
    } t_reg_idx;

    // Request to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_ctl;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GEOM_X,
        ST_GEOM_XW,
        ST_GEOM_Y,
        ST_GEOM_YW,
        ST_SPAN,
        ST_CHECK,
        ST_COL,
        ST_COLW,
        ST_ROW,
        ST_ROWW,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_AVG,
        ST_AVGW,
        ST_REF_RD,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* src/block_luma_motion_detector_unit.sv */
// Top level of the tile-average luma motion detector.
`default_nettype none

`include "assert_macros.svh"

// Takes one 8-bit luma pixel per transfer and reports, from the second frame on, the
// absolute change of each tile's average against the previous frame as each tile
// completes. Pixels are handled one at a time by a sequencer around one shared
// one-bit-per-cycle divider: a pixel outside the tile grid ends at the grid check, a
// pixel inside runs the tile column and row divisions, and the last pixel of a tile
// adds the average division and the reference memory read, and waits while the
// previous report is still held in the output register for the receiver. The first
// pixel after reset or after any register write first derives the tile size by
// dividing the frame size by the grid size. Tile sums live in a MAX_TILE_COLS-entry
// RAM and references in a MAX_TILE_COLS*MAX_TILE_ROWS RAM.
module block_luma_motion_detector_unit #(
    parameter int MAX_TILE_COLS = lmd_pkg::MAX_TILE_COLS_DEF,
    parameter int MAX_TILE_ROWS = lmd_pkg::MAX_TILE_ROWS_DEF,
    parameter int MAX_DIM       = lmd_pkg::MAX_DIM_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire logic [7:0]                i_s_axis_tdata,   // luma
    input  wire logic                      i_s_axis_tuser,   // frame_start
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    output logic [23:0]                    o_m_axis_tdata,   // tile_col, tile_row, difference
    output logic                           o_m_axis_tlast,
    input  wire logic                      i_cfg_we,
    input  wire lmd_pkg::t_reg_idx         i_cfg_index,
    input  wire logic [lmd_pkg::DIM_CFG_W-1:0] i_cfg_wdata
);

    import lmd_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int TC_W   = $clog2(MAX_TILE_COLS + 1);
    localparam int TR_W   = $clog2(MAX_TILE_ROWS + 1);
    localparam int COL_W  = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
    localparam int ROW_W  = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
    localparam int NREF   = MAX_TILE_COLS * MAX_TILE_ROWS;
    localparam int IDX_W  = (NREF > 1) ? $clog2(NREF) : 1;
    localparam int AREA_W = 2 * DIM_W;

    // Configuration registers.
    logic [DIM_CFG_W-1:0]  r_frame_width, r_frame_height;
    logic [GRID_CFG_W-1:0] r_block_cols, r_block_rows;

    // Clamped geometry.
    logic [DIM_W-1:0] w_c, h_c, wrap_w, wrap_h;
    logic [TC_W-1:0]  cols_c;
    logic [TR_W-1:0]  rows_c;

    // Sequencer and datapath.
    t_state r_state, n_state;
    logic   r_geom_ok;
    logic   r_first;
    logic [DIM_W-1:0]  r_cx, r_cy, r_span_x, r_span_y, r_xrem, r_yrem;
    logic [AREA_W-1:0] r_area;
    logic [POS_W-1:0]  r_pixel_x, r_pixel_y, r_cur_x, r_cur_y;
    logic [POS_W-1:0]  cur_x, cur_y, n_pixel_x, n_pixel_y;
    logic [DIM_W-1:0]  nx, ny;
    logic [LUMA_W-1:0] r_luma;
    logic [COL_W-1:0]  r_c;
    logic [ROW_W-1:0]  r_r;
    logic [IDX_W-1:0]  r_idx;
    logic              r_tile_end, r_last, r_acc_hit;
    logic [ACC_W-1:0]  r_sum, acc_sum;
    logic [LUMA_W-1:0] r_avg, diff;
    logic [MAX_TILE_COLS-1:0] r_acc_vld;
    logic              in_xfer, in_grid, proceed, out_load, in_div_wait;

    // Output register.
    logic              r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_col, r_out_row;
    logic [LUMA_W-1:0] r_out_diff;
    logic              r_out_last;

    // Divider and memory hookup.
    t_div_ctl          div_ctl;
    logic [DIV_W-1:0]  div_dividend, div_divisor, div_quot, div_rem;
    logic              div_done;
    logic              acc_re, acc_we, ref_re, ref_we;
    logic [ACC_W-1:0]  acc_rdata;
    logic [LUMA_W-1:0] ref_rdata;

    // Clamp the registers to the supported ranges; zero sizes wrap as one.
    always_comb begin
        w_c    = (int'(r_frame_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_frame_width);
        h_c    = (int'(r_frame_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_frame_height);
        cols_c = (int'(r_block_cols) > MAX_TILE_COLS) ? TC_W'(MAX_TILE_COLS)
                                                      : TC_W'(r_block_cols);
        rows_c = (int'(r_block_rows) > MAX_TILE_ROWS) ? TR_W'(MAX_TILE_ROWS)
                                                      : TR_W'(r_block_rows);
        wrap_w = (w_c == '0) ? DIM_W'(1) : w_c;
        wrap_h = (h_c == '0) ? DIM_W'(1) : h_c;
    end

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // Raster position of the incoming pixel and of the one after it.
    always_comb begin
        cur_x = i_s_axis_tuser ? '0 : r_pixel_x;
        cur_y = i_s_axis_tuser ? '0 : r_pixel_y;
        nx    = DIM_W'(cur_x) + DIM_W'(1);
        ny    = DIM_W'(cur_y) + DIM_W'(1);
        if (nx >= wrap_w) begin
            n_pixel_x = '0;
            n_pixel_y = (ny >= wrap_h) ? '0 : POS_W'(ny);
        end else begin
            n_pixel_x = POS_W'(nx);
            n_pixel_y = cur_y;
        end
    end

    assign in_grid = (r_cx != '0) && (r_cy != '0) &&
                     (DIM_W'(r_cur_x) < r_span_x) && (DIM_W'(r_cur_y) < r_span_y);
    assign proceed = r_first || !r_out_valid || i_m_axis_tready;

    // States in which the sequencer waits for the divider.
    assign in_div_wait = r_state inside {ST_GEOM_XW, ST_GEOM_YW, ST_COLW, ST_ROWW, ST_AVGW};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (in_xfer) n_state = r_geom_ok ? ST_CHECK : ST_GEOM_X;
            ST_GEOM_X:  n_state = (cols_c == '0) ? ST_GEOM_Y : ST_GEOM_XW;
            ST_GEOM_XW: if (div_done) n_state = ST_GEOM_Y;
            ST_GEOM_Y:  n_state = (rows_c == '0) ? ST_SPAN : ST_GEOM_YW;
            ST_GEOM_YW: if (div_done) n_state = ST_SPAN;
            ST_SPAN:    n_state = ST_CHECK;
            ST_CHECK:   n_state = in_grid ? ST_COL : ST_IDLE;
            ST_COL:     n_state = ST_COLW;
            ST_COLW:    if (div_done) n_state = ST_ROW;
            ST_ROW:     n_state = ST_ROWW;
            ST_ROWW:    if (div_done) n_state = ST_ACC_RD;
            ST_ACC_RD:  n_state = ST_ACC_WR;
            ST_ACC_WR:  n_state = r_tile_end ? ST_AVG : ST_IDLE;
            ST_AVG:     n_state = ST_AVGW;
            ST_AVGW:    if (div_done) n_state = ST_REF_RD;
            ST_REF_RD:  n_state = ST_EMIT;
            ST_EMIT:    if (proceed) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control strobes for each state.
    always_comb begin
        o_s_axis_tready = 1'b0;
        div_ctl         = '0;
        div_dividend    = '0;
        div_divisor     = '0;
        acc_re          = 1'b0;
        acc_we          = 1'b0;
        ref_re          = 1'b0;
        ref_we          = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_GEOM_X: begin
                div_ctl.start = (cols_c != '0);
                div_ctl.nbits = DIV_CNT_W'(DIM_W);
                div_dividend  = DIV_W'(w_c);
                div_divisor   = DIV_W'(cols_c);
            end
            ST_GEOM_Y: begin
                div_ctl.start = (rows_c != '0);
                div_ctl.nbits = DIV_CNT_W'(DIM_W);
                div_dividend  = DIV_W'(h_c);
                div_divisor   = DIV_W'(rows_c);
            end
            ST_COL: begin
                div_ctl.start = 1'b1;
                div_ctl.nbits = DIV_CNT_W'(POS_W);
                div_dividend  = DIV_W'(r_cur_x);
                div_divisor   = DIV_W'(r_cx);
            end
            ST_ROW: begin
                div_ctl.start = 1'b1;
                div_ctl.nbits = DIV_CNT_W'(POS_W);
                div_dividend  = DIV_W'(r_cur_y);
                div_divisor   = DIV_W'(r_cy);
            end
            ST_ACC_RD: acc_re = 1'b1;
            ST_ACC_WR: acc_we = !r_tile_end;
            ST_AVG: begin
                div_ctl.start = 1'b1;
                div_ctl.nbits = DIV_CNT_W'(ACC_W);
                div_dividend  = r_sum;
                div_divisor   = DIV_W'(r_area);
            end
            ST_REF_RD: ref_re = 1'b1;
            ST_EMIT: begin
                ref_we   = proceed;
                out_load = proceed && !r_first;
            end
            default: ;
        endcase
    end

    assign acc_sum = (r_acc_hit ? acc_rdata : '0) + ACC_W'(r_luma);
    assign diff    = (r_avg >= ref_rdata) ? (r_avg - ref_rdata) : (ref_rdata - r_avg);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_geom_ok      <= 1'b0;
            r_first        <= 1'b1;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_block_cols   <= BLOCK_COLS_RST;
            r_block_rows   <= BLOCK_ROWS_RST;
            r_pixel_x      <= '0;
            r_pixel_y      <= '0;
            r_acc_vld      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_geom_ok <= 1'b0;
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                    REG_BLOCK_COLS:   r_block_cols   <= i_cfg_wdata[GRID_CFG_W-1:0];
                    REG_BLOCK_ROWS:   r_block_rows   <= i_cfg_wdata[GRID_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_SPAN) begin
                r_geom_ok <= 1'b1;
            end
            if (in_xfer) begin
                r_pixel_x <= n_pixel_x;
                r_pixel_y <= n_pixel_y;
                if (i_s_axis_tuser) begin
                    r_acc_vld <= '0;
                end
            end
            // A tile sum is either written back or emptied at its last pixel.
            if (r_state == ST_ACC_WR) begin
                r_acc_vld[r_c] <= !r_tile_end;
            end
            if (ref_we && r_last) begin
                r_first <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_luma  <= i_s_axis_tdata;
            r_cur_x <= cur_x;
            r_cur_y <= cur_y;
        end
        if (r_state == ST_GEOM_X && cols_c == '0) begin
            r_cx <= '0;
        end
        if (r_state == ST_GEOM_XW && div_done) begin
            r_cx <= DIM_W'(div_quot);
        end
        if (r_state == ST_GEOM_Y && rows_c == '0) begin
            r_cy <= '0;
        end
        if (r_state == ST_GEOM_YW && div_done) begin
            r_cy <= DIM_W'(div_quot);
        end
        if (r_state == ST_SPAN) begin
            r_area   <= AREA_W'(r_cx) * AREA_W'(r_cy);
            r_span_x <= DIM_W'(r_cx * DIM_W'(cols_c));
            r_span_y <= DIM_W'(r_cy * DIM_W'(rows_c));
        end
        if (r_state == ST_COLW && div_done) begin
            r_c    <= COL_W'(div_quot);
            r_xrem <= DIM_W'(div_rem);
        end
        if (r_state == ST_ROWW && div_done) begin
            r_r    <= ROW_W'(div_quot);
            r_yrem <= DIM_W'(div_rem);
        end
        if (r_state == ST_ACC_RD) begin
            r_acc_hit  <= r_acc_vld[r_c];
            r_idx      <= IDX_W'(r_r) * IDX_W'(cols_c) + IDX_W'(r_c);
            r_tile_end <= (r_xrem == r_cx - DIM_W'(1)) && (r_yrem == r_cy - DIM_W'(1));
            r_last     <= (TR_W'(r_r) == rows_c - TR_W'(1)) &&
                          (TC_W'(r_c) == cols_c - TC_W'(1));
        end
        if (r_state == ST_ACC_WR) begin
            r_sum <= acc_sum;
        end
        if (r_state == ST_AVGW && div_done) begin
            r_avg <= (div_quot > DIV_W'(255)) ? 8'hFF : div_quot[LUMA_W-1:0];
        end
        if (out_load) begin
            r_out_col  <= OUT_IDX_W'(r_c);
            r_out_row  <= OUT_IDX_W'(r_r);
            r_out_diff <= diff;
            r_out_last <= r_last;
        end
    end

    // Shared divider.
    lmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Running tile sums, one per tile column.
    lmd_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_TILE_COLS),
        .AW    (COL_W)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_c),
        .i_wdata (acc_sum),
        .i_re    (acc_re),
        .i_raddr (r_c),
        .o_rdata (acc_rdata)
    );

    // Reference tile averages of the previous frame.
    lmd_ram #(
        .WIDTH (LUMA_W),
        .DEPTH (NREF),
        .AW    (IDX_W)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (r_idx),
        .i_wdata (r_avg),
        .i_re    (ref_re),
        .i_raddr (r_idx),
        .o_rdata (ref_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_diff, r_out_row, r_out_col};
    assign o_m_axis_tlast  = r_out_last;

    `LMD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_xfer |=> !o_s_axis_tready, "busy after accept")
    `LMD_ASSERT(a_first_sticky, i_clk, i_rst_n, !r_first |=> !r_first, "first-frame flag set again")
    `LMD_ASSERT(a_done_in_wait, i_clk, i_rst_n, div_done |-> in_div_wait, "divider done outside a wait")

endmodule

`default_nettype wire

/* src/lmd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/lmd_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

`include "assert_macros.svh"

module lmd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lmd_pkg::t_div_ctl i_ctl,
    input  wire logic [lmd_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [lmd_pkg::DIV_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [lmd_pkg::DIV_W-1:0] o_quot,
    output logic [lmd_pkg::DIV_W-1:0] o_rem
);

    import lmd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_dvd;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     r_quot;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W:0]       trial;
    logic                 qbit;
    logic [DIV_CNT_W-1:0] pre_shift;

    // Align the dividend so that only the requested number of bits is iterated.
    assign pre_shift = DIV_CNT_W'(DIV_W) - i_ctl.nbits;

    // Trial subtraction of one step.
    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign qbit  = (trial >= {1'b0, r_dvs});

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd  <= i_dividend << pre_shift;
            r_dvs  <= i_divisor;
            r_quot <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], qbit};
            r_rem  <= qbit ? DIV_W'(trial - {1'b0, r_dvs}) : trial[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    `LMD_ASSERT(a_no_restart, i_clk, i_rst_n, r_busy |-> !i_ctl.start, "divider restarted while busy")
    `LMD_ASSERT(a_done_ends_run, i_clk, i_rst_n, $fell(r_busy) |-> r_done, "divider stopped without done")
    `LMD_ASSERT(a_start_runs, i_clk, i_rst_n, (i_ctl.start && i_ctl.nbits != '0) |=> r_busy, "divider did not run after start")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the tile-average luma motion detector.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lmd_pkg::*;

    // One pixel on the input stream.
    typedef struct {
        logic [7:0] luma;
        logic       frame_start;
    } t_pixel;

    // One tile report on the output stream.
    typedef struct {
        logic [6:0] tile_col;
        logic [6:0] tile_row;
        logic [7:0] difference;
        logic       last_tile;
    } t_tile_report;

    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 128;
    localparam int DIM_LIMIT = 4096;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam longint CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    t_reg_idx    cfg_index = REG_FRAME_WIDTH;
    logic [DIM_CFG_W-1:0] cfg_wdata = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [23:0]  o_m_axis_tdata;
    wire         o_m_axis_tlast;

    block_luma_motion_detector_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the registers and of the detector state.
    logic [12:0] frame_width_reg  = 13'd1920;
    logic [12:0] frame_height_reg = 13'd1080;
    logic [7:0]  block_cols_reg   = 8'd12;
    logic [7:0]  block_rows_reg   = 8'd8;
    int unsigned pos_x = 0;
    int unsigned pos_y = 0;
    int unsigned column_sums [MAX_COLS];
    logic [7:0]  tile_refs [MAX_COLS*MAX_ROWS];
    logic        in_first_frame = 1'b1;

    t_pixel       pixel_q [$];
    t_tile_report report_q [$];
    int           mismatches = 0;
    bit           no_gaps = 1'b0;
    bit           hold_request = 1'b0;

    initial begin
        foreach (column_sums[i]) column_sums[i] = 0;
        foreach (tile_refs[i]) tile_refs[i] = 8'd0;
    end

    // Advances the shadow state by one pixel and queues the tile report it causes.
    task automatic track_pixel(input logic [7:0] luma, input logic frame_start);
        int unsigned w, h, cols, rows, wrap_w, wrap_h, cx, cy, x, y, c, r;
        int unsigned avg, idx, prev;
        logic last;
        t_tile_report rep;
        w = (frame_width_reg > DIM_LIMIT) ? DIM_LIMIT : frame_width_reg;
        h = (frame_height_reg > DIM_LIMIT) ? DIM_LIMIT : frame_height_reg;
        cols = (block_cols_reg > MAX_COLS) ? MAX_COLS : block_cols_reg;
        rows = (block_rows_reg > MAX_ROWS) ? MAX_ROWS : block_rows_reg;
        wrap_w = (w == 0) ? 1 : w;
        wrap_h = (h == 0) ? 1 : h;
        cx = (cols == 0) ? 0 : w / cols;
        cy = (rows == 0) ? 0 : h / rows;
        if (frame_start) begin
            pos_x = 0;
            pos_y = 0;
            foreach (column_sums[i]) column_sums[i] = 0;
        end
        x = pos_x;
        y = pos_y;
        if (cx != 0 && cy != 0 && x < cx * cols && y < cy * rows) begin
            c = x / cx;
            r = y / cy;
            if (c < MAX_COLS && r < MAX_ROWS) begin
                column_sums[c] += luma;
                // Bottom-right pixel of a tile closes it.
                if (x % cx == cx - 1 && y % cy == cy - 1) begin
                    avg = column_sums[c] / (cx * cy);
                    idx = r * cols + c;
                    last = (r == rows - 1) && (c == cols - 1);
                    column_sums[c] = 0;
                    if (avg > 255) avg = 255;
                    if (idx < MAX_COLS * MAX_ROWS) begin
                        prev = tile_refs[idx];
                        if (!in_first_frame) begin
                            rep.tile_col = c[6:0];
                            rep.tile_row = r[6:0];
                            rep.difference = 8'((avg >= prev) ? avg - prev : prev - avg);
                            rep.last_tile = last;
                            report_q.push_back(rep);
                        end
                        tile_refs[idx] = avg[7:0];
                    end
                    if (last) in_first_frame = 1'b0;
                end
            end
        end
        x++;
        if (x >= wrap_w) begin
            x = 0;
            y++;
            if (y >= wrap_h) y = 0;
        end
        pos_x = x;
        pos_y = y;
    endtask

    // Pixel driver: presents queued pixels with random gaps.
    int unsigned gap_cnt = 0;
    always @(posedge i_clk) begin
        t_pixel next_pix;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                track_pixel(s_tdata, s_tuser);
            end
            if (!s_valid || o_s_axis_tready) begin
                if (gap_cnt != 0) begin
                    gap_cnt <= gap_cnt - 1;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    next_pix = pixel_q.pop_front();
                    s_tdata <= next_pix.luma;
                    s_tuser <= next_pix.frame_start;
                    s_valid <= 1'b1;
                    gap_cnt <= no_gaps ? 0 : $urandom_range(0, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor: random stalls, one long hold-off, and the field checks.
    int unsigned stall_cnt = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_tile_report want;
        int unsigned draw;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (report_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected tile report: tdata=%h tlast=%b",
                                 o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    want = report_q.pop_front();
                    if (o_m_axis_tdata[6:0] !== want.tile_col ||
                        o_m_axis_tdata[13:7] !== want.tile_row ||
                        o_m_axis_tdata[21:14] !== want.difference ||
                        o_m_axis_tdata[23:22] !== 2'b00 ||
                        o_m_axis_tlast !== want.last_tile) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Tile report mismatch: expected col %0d row %0d",
                                     want.tile_col, want.tile_row,
                                     " diff %0d last %b,", want.difference,
                                     want.last_tile,
                                     " got col %0d row %0d diff %0d last %b",
                                     o_m_axis_tdata[6:0], o_m_axis_tdata[13:7],
                                     o_m_axis_tdata[21:14], o_m_axis_tlast);
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done <= 1'b1;
                stall_cnt <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (stall_cnt != 0) begin
                stall_cnt <= stall_cnt - 1;
                m_ready <= (stall_cnt == 1);
            end else if (o_m_axis_tvalid && m_ready) begin
                draw = no_gaps ? 0 : $urandom_range(0, 13);
                stall_cnt <= draw;
                m_ready <= (draw == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Run limit.
    longint cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Waits until every pixel is in and every report is out, then lets the block settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || s_valid || report_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [12:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_FRAME_WIDTH:  frame_width_reg = value;
            REG_FRAME_HEIGHT: frame_height_reg = value;
            REG_BLOCK_COLS:   block_cols_reg = value[7:0];
            default:          block_rows_reg = value[7:0];
        endcase
    endtask

    // Reprograms the geometry while idle and queues a number of frames.
    task automatic run_geometry(input int w, input int h, input int cols, input int rows,
                                input int frames, input int pixels_per_frame,
                                input bit clean_start);
        t_pixel p;
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 13'(w));
        write_reg(REG_FRAME_HEIGHT, 13'(h));
        write_reg(REG_BLOCK_COLS, 13'(cols));
        write_reg(REG_BLOCK_ROWS, 13'(rows));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int f = 0; f < frames; f++) begin
            for (int i = 0; i < pixels_per_frame; i++) begin
                p.luma = 8'($urandom_range(0, 255));
                if (i == 0)
                    p.frame_start = (f == 0 || clean_start) ? 1'b1
                                                            : ($urandom_range(0, 9) != 0);
                else
                    p.frame_start = !clean_start && ($urandom_range(0, 40) == 0);
                pixel_q.push_back(p);
            end
        end
    endtask

    initial begin
        t_pixel p;
        int cols, rows, w, h;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Largest grid first, one pixel per tile, so every later grid reads
        // only references that have been written.
        write_reg(REG_FRAME_WIDTH, 13'd16);
        write_reg(REG_FRAME_HEIGHT, 13'd8);
        write_reg(REG_BLOCK_COLS, 13'd16);
        write_reg(REG_BLOCK_ROWS, 13'd8);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        // First frame alternates black and white, second inverts it for full-scale change.
        for (int f = 0; f < 2; f++)
            for (int i = 0; i < 128; i++) begin
                p.luma = ((i + f) % 2) ? 8'd255 : 8'd0;
                p.frame_start = (i == 0);
                pixel_q.push_back(p);
            end
        wait_drained();

        // Random pixels with the output held off long enough to back up the input.
        for (int i = 0; i < 64; i++) begin
            p.luma = 8'($urandom_range(0, 255));
            p.frame_start = (i == 0);
            pixel_q.push_back(p);
        end
        hold_request = 1'b1;

        // Single-row and single-column grids, with grid size clamping.
        run_geometry(128, 1, 255, 1, 1, 128, 1'b1);
        run_geometry(1, 128, 1, 128, 1, 64, 1'b1);
        // Oversized frame dimensions clamp to the maximum.
        run_geometry(8191, 1, 128, 1, 1, 64, 1'b1);
        run_geometry(1, 8191, 1, 128, 1, 64, 1'b1);
        // Zero registers and a grid finer than the frame: nothing is reported.
        run_geometry(0, 0, 0, 200, 1, 20, 1'b0);
        run_geometry(5, 3, 8, 1, 2, 15, 1'b0);
        run_geometry(4, 4, 2, 0, 2, 16, 1'b0);

        // Random small geometries with tiles of one or more pixels.
        for (int k = 0; k < 3; k++) begin
            cols = $urandom_range(1, 6);
            rows = $urandom_range(1, 4);
            w = cols * $urandom_range(1, 3) + $urandom_range(0, 2);
            h = rows * $urandom_range(1, 2) + $urandom_range(0, 1);
            run_geometry(w, h, cols, rows, 2, w * h, ($urandom_range(0, 2) == 0));
        end

        wait_drained();
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+src
src/lmd_pkg.sv
src/lmd_ram.sv
src/lmd_div.sv
src/block_luma_motion_detector_unit.sv
verif/tb_top.sv
